### hdl/cbpq_pkg.sv
package cbpq_pkg;

  localparam int NUM_BUCKETS  = 256;
  localparam int NUM_ELEMENTS = 1024;

  localparam int BKT_W  = 8;
  localparam int ELEM_W = 10;
  localparam int BIU_W  = BKT_W + 1;
  localparam int CNT_W  = $clog2(NUM_ELEMENTS + 1);
  localparam int MODE_W = 3;
  localparam int STAT_W = 3;

  localparam logic [BIU_W-1:0] BIU_MAX = BIU_W'(NUM_BUCKETS);

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT      = 3'd0,
    OP_REMOVE_MIN  = 3'd1,
    OP_REMOVE_ELEM = 3'd2,
    OP_MOVE        = 3'd3,
    OP_EMPTY_QUERY = 3'd4,
    OP_CLEAR       = 3'd5,
    OP_NOP         = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_POP_H,
    S_MV_RD,
    S_MV_AP,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [BKT_W-1:0]  bucket;
    logic [ELEM_W-1:0] element;
    logic [BKT_W-1:0]  to_bucket;
    logic              bkt_bad;
    logic              elem_bad;
  } cmd_t;

  typedef struct packed {
    logic [ELEM_W-1:0] head;
    logic [ELEM_W-1:0] tail;
  } ht_t;

  typedef struct packed {
    logic             queued;
    logic [BKT_W-1:0] bucket;
  } meta_t;

  typedef struct packed {
    logic [ELEM_W-1:0] removed_element;
    status_t           status;
    logic              queue_empty;
    logic [BKT_W-1:0]  current_bucket;
  } res_t;

endpackage

### hdl/cbpq_ram.sv
module cbpq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/cbpq_front.sv
module cbpq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [cbpq_pkg::MODE_W-1:0]  in_mode,
  input  logic [cbpq_pkg::BKT_W-1:0]   in_bucket,
  input  logic [cbpq_pkg::ELEM_W-1:0]  in_element,
  input  logic [cbpq_pkg::BKT_W-1:0]   in_to_bucket,
  input  logic [cbpq_pkg::BIU_W-1:0]   biu,
  input  logic                         hold,
  output cbpq_pkg::cmd_t               cmd,
  output logic                         cmd_valid,
  input  logic                         cmd_take
);
  import cbpq_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       push_ok;
  logic       b_bad, tb_bad;

  assign in_full   = (cnt_r == 2'd2) || hold;
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  assign b_bad  = {1'b0, in_bucket} >= biu;
  assign tb_bad = {1'b0, in_to_bucket} >= biu;

  always_comb begin
    dec.bucket    = in_bucket;
    dec.element   = in_element;
    dec.to_bucket = in_to_bucket;
    dec.bkt_bad   = 1'b0;
    dec.elem_bad  = 1'b0;
    unique case (in_mode)
      OP_INSERT: begin
        dec.op       = OP_INSERT;
        dec.bkt_bad  = b_bad;
        dec.elem_bad = {1'b0, in_element} >= (ELEM_W + 1)'(NUM_ELEMENTS);
      end
      OP_REMOVE_MIN: dec.op = OP_REMOVE_MIN;
      OP_REMOVE_ELEM: begin
        dec.op       = OP_REMOVE_ELEM;
        dec.bkt_bad  = b_bad;
        dec.elem_bad = {1'b0, in_element} >= (ELEM_W + 1)'(NUM_ELEMENTS);
      end
      OP_MOVE: begin
        dec.op       = OP_MOVE;
        dec.bkt_bad  = b_bad || tb_bad;
        dec.elem_bad = {1'b0, in_element} >= (ELEM_W + 1)'(NUM_ELEMENTS);
      end
      OP_EMPTY_QUERY: dec.op = OP_EMPTY_QUERY;
      OP_CLEAR: dec.op = OP_CLEAR;
      default: dec.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= dec;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (cmd_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, cmd_take};
    end
  end

endmodule

### hdl/cbpq_back.sv
module cbpq_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cbpq_pkg::cmd_t             cmd,
  input  logic                       cmd_valid,
  output logic                       cmd_take,
  input  logic [cbpq_pkg::BIU_W-1:0] biu,
  output logic                       init_busy,
  output cbpq_pkg::res_t             res,
  output logic                       res_valid,
  input  logic                       res_pop
);
  import cbpq_pkg::*;

  state_t                 state_r, state_nxt;
  cmd_t                   cur_r;
  logic [BKT_W-1:0]       pos_r, start_r, steps_r, scan_r;
  logic [ELEM_W-1:0]      sweep_r;
  logic                   clr_rsp_r;
  logic [CNT_W-1:0]       count_r;
  logic [NUM_BUCKETS-1:0] nonempty_r;
  status_t                status_r;
  logic [ELEM_W-1:0]      removed_r;
  res_t                   res_r;
  logic                   res_valid_r;

  logic              ht_we;
  logic [BKT_W-1:0]  ht_wa, ht_ra;
  ht_t               ht_wd, ht_rd;
  logic              nx_we, pv_we, mt_we;
  logic [ELEM_W-1:0] nx_wa, nx_wd, nx_rd, pv_wa, pv_wd, pv_rd, mt_wa, el_ra;
  meta_t             mt_wd, mt_rd;

  logic             unl_en, app_en, present, sweep_last, scan_hit, scan_last, res_load;
  logic [BKT_W-1:0] app_bkt, scan_start, pos_step;

  cbpq_ram #(.W($bits(ht_t)), .D(NUM_BUCKETS)) u_ht (
    .clk(clk), .we(ht_we), .waddr(ht_wa), .wdata(ht_wd), .raddr(ht_ra), .rdata(ht_rd));
  cbpq_ram #(.W(ELEM_W), .D(NUM_ELEMENTS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(el_ra), .rdata(nx_rd));
  cbpq_ram #(.W(ELEM_W), .D(NUM_ELEMENTS)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(el_ra), .rdata(pv_rd));
  cbpq_ram #(.W($bits(meta_t)), .D(NUM_ELEMENTS)) u_meta (
    .clk(clk), .we(mt_we), .waddr(mt_wa), .wdata(mt_wd), .raddr(el_ra), .rdata(mt_rd));

  assign present    = mt_rd.queued && (mt_rd.bucket == cur_r.bucket);
  assign sweep_last = (sweep_r == ELEM_W'(NUM_ELEMENTS - 1));
  assign scan_hit   = nonempty_r[pos_r];
  assign scan_last  = ({1'b0, steps_r} == biu - BIU_W'(1));
  assign pos_step   = ({1'b0, pos_r} == biu - BIU_W'(1)) ? '0 : pos_r + BKT_W'(1);
  // scan position past the wrap point restarts at bucket zero
  assign scan_start = ({1'b0, scan_r} >= biu) ? '0 : scan_r;
  assign res_load   = (state_r == S_OUT) && (!res_valid_r || res_pop);
  assign cmd_take   = (state_r == S_IDLE) && cmd_valid;
  assign init_busy  = (state_r == S_CLEAR) && !clr_rsp_r;
  assign res        = res_r;
  assign res_valid  = res_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sweep_last) state_nxt = clr_rsp_r ? S_OUT : S_IDLE;
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_INSERT, OP_REMOVE_ELEM, OP_MOVE:
              state_nxt = (cmd.bkt_bad || cmd.elem_bad) ? S_OUT : S_DEC;
            OP_REMOVE_MIN, OP_EMPTY_QUERY: state_nxt = S_SCAN;
            OP_CLEAR: state_nxt = S_CLEAR;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_DEC: state_nxt = (cur_r.op == OP_MOVE && present) ? S_MV_RD : S_OUT;
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = (cur_r.op == OP_REMOVE_MIN) ? S_POP_H : S_OUT;
        end else if (scan_last) begin
          state_nxt = S_OUT;
        end
      end
      S_POP_H: state_nxt = S_DEC;
      S_MV_RD: state_nxt = S_MV_AP;
      S_MV_AP: state_nxt = S_OUT;
      S_OUT:   if (res_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    unl_en  = 1'b0;
    app_en  = 1'b0;
    app_bkt = cur_r.bucket;
    ht_ra   = cur_r.bucket;
    el_ra   = cur_r.element;
    unique case (state_r)
      S_IDLE: begin
        ht_ra = cmd.bucket;
        el_ra = cmd.element;
      end
      S_DEC: begin
        unique case (cur_r.op)
          OP_INSERT:                app_en = !mt_rd.queued;
          OP_REMOVE_ELEM, OP_MOVE:  unl_en = present;
          OP_REMOVE_MIN:            unl_en = 1'b1;
          default: ;
        endcase
      end
      S_SCAN: ht_ra = pos_r;
      S_POP_H: begin
        ht_ra = pos_r;
        el_ra = ht_rd.head;
      end
      S_MV_RD: ht_ra = cur_r.to_bucket;
      S_MV_AP: begin
        ht_ra   = cur_r.to_bucket;
        app_en  = 1'b1;
        app_bkt = cur_r.to_bucket;
      end
      default: ;
    endcase
  end

  // link updates: one write per table per cycle covers unlink and append
  always_comb begin
    ht_we = 1'b0; ht_wa = app_bkt; ht_wd = ht_rd;
    nx_we = 1'b0; nx_wa = '0; nx_wd = cur_r.element;
    pv_we = 1'b0; pv_wa = cur_r.element; pv_wd = ht_rd.tail;
    mt_we = 1'b0; mt_wa = cur_r.element; mt_wd = '{queued: 1'b0, bucket: cur_r.bucket};
    if (unl_en) begin
      mt_we = 1'b1;
      if (ht_rd.head == cur_r.element) begin
        if (ht_rd.tail != cur_r.element) begin
          ht_we = 1'b1;
          ht_wd = '{head: nx_rd, tail: ht_rd.tail};
        end
      end else if (ht_rd.tail == cur_r.element) begin
        ht_we = 1'b1;
        ht_wd = '{head: ht_rd.head, tail: pv_rd};
      end else begin
        nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
        pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
      end
    end
    if (app_en) begin
      mt_we = 1'b1;
      mt_wd = '{queued: 1'b1, bucket: app_bkt};
      ht_we = 1'b1;
      if (nonempty_r[app_bkt]) begin
        nx_we = 1'b1; nx_wa = ht_rd.tail;
        pv_we = 1'b1;
        ht_wd = '{head: ht_rd.head, tail: cur_r.element};
      end else begin
        ht_wd = '{head: cur_r.element, tail: cur_r.element};
      end
    end
    if (state_r == S_CLEAR) begin
      mt_we = 1'b1;
      mt_wa = sweep_r;
      mt_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cur_r <= cmd;
    if (state_r == S_POP_H) begin
      cur_r.element <= ht_rd.head;
      cur_r.bucket  <= pos_r;
    end
    if (res_load) begin
      res_r <= '{removed_element: removed_r, status: status_r,
                 queue_empty: (count_r == '0), current_bucket: scan_r};
    end
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      clr_rsp_r   <= 1'b0;
      nonempty_r  <= '0;
      count_r     <= '0;
      scan_r      <= '0;
      res_valid_r <= 1'b0;
      status_r    <= ST_OK;
      removed_r   <= '0;
      pos_r       <= '0;
      start_r     <= '0;
      steps_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) sweep_r <= sweep_r + ELEM_W'(1);
      if (cmd_take) begin
        removed_r <= '0;
        if (cmd.bkt_bad) status_r <= ST_RANGE;
        else if (cmd.elem_bad) status_r <= ST_ABSENT;
        else status_r <= ST_OK;
        pos_r   <= scan_start;
        start_r <= scan_start;
        steps_r <= '0;
        if (cmd.op == OP_REMOVE_MIN || cmd.op == OP_EMPTY_QUERY) scan_r <= scan_start;
        if (cmd.op == OP_CLEAR) begin
          nonempty_r <= '0;
          count_r    <= '0;
          scan_r     <= '0;
          sweep_r    <= '0;
          clr_rsp_r  <= 1'b1;
        end
      end
      if (state_r == S_DEC) begin
        if (cur_r.op == OP_INSERT && mt_rd.queued) status_r <= ST_DUP;
        if ((cur_r.op == OP_REMOVE_ELEM || cur_r.op == OP_MOVE) && !present)
          status_r <= ST_ABSENT;
        if (cur_r.op == OP_REMOVE_MIN) removed_r <= cur_r.element;
      end
      if (state_r == S_SCAN) begin
        if (scan_hit) begin
          scan_r <= pos_r;
        end else if (scan_last) begin
          scan_r   <= start_r;
          status_r <= ST_EMPTY;
        end else begin
          pos_r   <= pos_step;
          steps_r <= steps_r + BKT_W'(1);
        end
      end
      if (unl_en && ht_rd.head == cur_r.element && ht_rd.tail == cur_r.element)
        nonempty_r[cur_r.bucket] <= 1'b0;
      if (app_en) nonempty_r[app_bkt] <= 1'b1;
      if (app_en) count_r <= count_r + CNT_W'(1);
      else if (unl_en) count_r <= count_r - CNT_W'(1);
      if (res_load) res_valid_r <= 1'b1;
      else if (res_pop) res_valid_r <= 1'b0;
    end
  end

endmodule

### hdl/circular_bucket_priority_queue_core.sv
// channel   | handshake              | beat fields
// ----------+------------------------+------------------------------------------------
// in        | in_push / in_full      | in_mode, in_bucket, in_element, in_to_bucket
// out       | out_pop / out_empty    | out_removed_element, out_status, out_queue_empty,
//           |                        | out_current_bucket
// cfg       | cfg_valid / cfg_ready  | cfg_data (buckets in use)
//
// Insert and remove element pass decode, then output; range failures go to output
// directly; move adds a target read and an append. Remove-min and empty query step one
// bucket per cycle; remove-min then pops the head and decodes. Clear sweeps the element
// table, one entry a cycle; after reset the same sweep runs with in_full held high.
// A two-beat input queue and a result register let either side stall alone.
module circular_bucket_priority_queue_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [cbpq_pkg::MODE_W-1:0]  in_mode,
  input  logic [cbpq_pkg::BKT_W-1:0]   in_bucket,
  input  logic [cbpq_pkg::ELEM_W-1:0]  in_element,
  input  logic [cbpq_pkg::BKT_W-1:0]   in_to_bucket,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [cbpq_pkg::ELEM_W-1:0]  out_removed_element,
  output logic [cbpq_pkg::STAT_W-1:0]  out_status,
  output logic                         out_queue_empty,
  output logic [cbpq_pkg::BKT_W-1:0]   out_current_bucket,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cbpq_pkg::BIU_W-1:0]   cfg_data
);
  import cbpq_pkg::*;

  logic [BIU_W-1:0] biu_r;
  cmd_t             cmd;
  logic             cmd_valid, cmd_take, init_busy, res_valid;
  res_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r <= BIU_MAX;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) biu_r <= BIU_W'(1);
      else if (cfg_data > BIU_MAX) biu_r <= BIU_MAX;
      else biu_r <= cfg_data;
    end
  end

  cbpq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_mode(in_mode), .in_bucket(in_bucket), .in_element(in_element),
    .in_to_bucket(in_to_bucket), .biu(biu_r), .hold(init_busy),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take));

  cbpq_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take), .biu(biu_r), .init_busy(init_busy),
    .res(res), .res_valid(res_valid), .res_pop(out_pop));

  assign out_empty           = !res_valid;
  assign out_removed_element = res.removed_element;
  assign out_status          = res.status;
  assign out_queue_empty     = res.queue_empty;
  assign out_current_bucket  = res.current_bucket;

endmodule

### hdl/cbpq_checker.sv
module cbpq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [cbpq_pkg::ELEM_W-1:0] out_removed_element,
  input logic [cbpq_pkg::STAT_W-1:0] out_status
);
  import cbpq_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  a_reset_busy: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input open during table sweep");

  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_removed_element != '0) |-> out_status == ST_OK)
    else $error("popped element with error status");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)
                                  && $stable(out_removed_element)))
    else $error("stalled result changed");

endmodule

bind circular_bucket_priority_queue_core cbpq_checker u_cbpq_checker (
  .clk(clk), .rst_n(rst_n), .in_full(in_full), .out_empty(out_empty),
  .out_pop(out_pop), .out_removed_element(out_removed_element),
  .out_status(out_status));
